// ===== src/idiv64_pkg.sv =====
package idiv64_pkg;

  localparam int DW    = 64;
  localparam int HW    = 32;
  localparam int NSTEP = DW;

  typedef logic [DW-1:0] word_t;

  typedef enum logic [1:0] {
    ACT_U64 = 2'd0,
    ACT_U32 = 2'd1,
    ACT_S32 = 2'd2,
    ACT_RSV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  localparam word_t MIN_S64  = {1'b1, {(DW-1){1'b0}}};
  localparam word_t ALL_ONES = {DW{1'b1}};

  // sideband that rides along with each item through the step stages
  typedef struct packed {
    status_t status;
    logic    q_neg;
    logic    r_neg;
  } side_t;

endpackage

// ===== src/integer_divider_64_top.sv =====
// 64-bit integer divider, quotient and remainder.
// Input channel: in_valid/in_stall with action, dividend_bits, divisor_bits.
//   action 0: unsigned 64/64; 1: unsigned 64 by low 32 divisor bits;
//   2: signed 64 by sign-extended low 32 divisor bits, truncating toward zero,
//   remainder takes the dividend's sign; 3 behaves as 0.
// Output channel: out_valid/out_stall with quotient_bits, remainder_bits, status.
//   status 0 ok, 1 divide by zero (quotient all ones, remainder = dividend),
//   2 signed overflow (quotient = most negative value, remainder 0).
// Throughput: one item per cycle while the output is not stalled. A result
//   passes through one operand stage, 64 restoring subtract stages (one
//   quotient bit each) and one sign-fix/output stage on its way to the output.
// When the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is lost or repeated.
// A synchronous reset empties the pipeline; in-flight items are dropped.
module integer_divider_64_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [63:0]       dividend_bits,
  input  logic [63:0]       divisor_bits,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       quotient_bits,
  output logic [63:0]       remainder_bits,
  output logic [1:0]        status
);
  import idiv64_pkg::*;

  logic  adv;
  logic  vld_s  [0:NSTEP];
  word_t rem_s  [0:NSTEP];
  word_t aq_s   [0:NSTEP];
  word_t den_s  [0:NSTEP];
  side_t side_s [0:NSTEP];

  action_t act;
  word_t   den_raw;
  logic    sgn;
  logic    dz;
  logic    ov;
  logic    a_neg;
  logic    b_neg;
  word_t   mag_a;
  word_t   mag_b;
  side_t   side_next;

  word_t   q_fix;
  word_t   r_fix;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // operand stage
  always_comb begin
    act = action_t'(action);
    sgn = 1'b0;
    case (act)
      ACT_U32: den_raw = {{(DW-HW){1'b0}}, divisor_bits[HW-1:0]};
      ACT_S32: begin
        den_raw = {{(DW-HW){divisor_bits[HW-1]}}, divisor_bits[HW-1:0]};
        sgn     = 1'b1;
      end
      default: den_raw = divisor_bits;
    endcase
    dz    = (den_raw == '0);
    ov    = sgn && (dividend_bits == MIN_S64) && (den_raw == ALL_ONES);
    a_neg = sgn && dividend_bits[DW-1] && !dz;
    b_neg = sgn && den_raw[DW-1];
    mag_a = a_neg ? (word_t'(0) - dividend_bits) : dividend_bits;
    mag_b = b_neg ? (word_t'(0) - den_raw) : den_raw;
    side_next.q_neg  = a_neg ^ b_neg;
    side_next.r_neg  = a_neg;
    side_next.status = dz ? ST_DIVZERO : (ov ? ST_OVERFLOW : ST_OK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (adv) begin
      vld_s[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_s[0]  <= '0;
      aq_s[0]   <= mag_a;
      den_s[0]  <= mag_b;
      side_s[0] <= side_next;
    end
  end

  // one quotient bit per stage; a zero divisor yields all ones and the dividend
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    idiv64_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (vld_s[i]),
      .in_rem   (rem_s[i]),
      .in_aq    (aq_s[i]),
      .in_den   (den_s[i]),
      .in_side  (side_s[i]),
      .out_vld  (vld_s[i+1]),
      .out_rem  (rem_s[i+1]),
      .out_aq   (aq_s[i+1]),
      .out_den  (den_s[i+1]),
      .out_side (side_s[i+1])
    );
  end

  // sign fix and overflow override
  always_comb begin
    q_fix = side_s[NSTEP].q_neg ? (word_t'(0) - aq_s[NSTEP]) : aq_s[NSTEP];
    r_fix = side_s[NSTEP].r_neg ? (word_t'(0) - rem_s[NSTEP]) : rem_s[NSTEP];
    if (side_s[NSTEP].status == ST_OVERFLOW) begin
      q_fix = MIN_S64;
      r_fix = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld_s[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quotient_bits  <= q_fix;
      remainder_bits <= r_fix;
      status         <= side_s[NSTEP].status;
    end
  end

endmodule

// ===== src/idiv64_step.sv =====
module idiv64_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_vld,
  input  idiv64_pkg::word_t  in_rem,
  input  idiv64_pkg::word_t  in_aq,
  input  idiv64_pkg::word_t  in_den,
  input  idiv64_pkg::side_t  in_side,
  output logic               out_vld,
  output idiv64_pkg::word_t  out_rem,
  output idiv64_pkg::word_t  out_aq,
  output idiv64_pkg::word_t  out_den,
  output idiv64_pkg::side_t  out_side
);
  import idiv64_pkg::*;

  logic [DW:0] rem_sh;
  word_t       diff;
  logic        ge;
  word_t       rem_next;
  word_t       aq_next;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    rem_sh   = {in_rem, in_aq[DW-1]};
    diff     = rem_sh[DW-1:0] - in_den;
    ge       = (rem_sh >= {1'b0, in_den});
    rem_next = ge ? diff : rem_sh[DW-1:0];
    aq_next  = {in_aq[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_aq   <= aq_next;
      out_den  <= in_den;
      out_side <= in_side;
    end
  end

endmodule
